// ===== rtl/core/srde_pkg.sv =====
package srde_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned RADIX_W = 5;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned ALPHA_W = 64;
	localparam int unsigned NUM_CHARS = 16;
	localparam int unsigned STACK_DEPTH = 32;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned CFG_IDX_W = 2;

	// bits of the dividend consumed per divider cycle
	localparam int unsigned DIV_BITS = 8;
	localparam int unsigned DIV_STEPS = VALUE_W / DIV_BITS;
	localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_DEL = 8'h7F;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HI = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic                start;
		logic [RADIX_W-1:0]  divisor;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/core/srde_divider.sv =====
module srde_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srde_pkg::div_ctl_t                ctl,
	input  logic [srde_pkg::VALUE_W-1:0]      dividend,
	output srde_pkg::div_stat_t               stat,
	output logic [srde_pkg::VALUE_W-1:0]      quotient,
	output logic [srde_pkg::DIGIT_W-1:0]      remainder
);

	logic                                busy_q;
	logic                                done_q;
	logic [srde_pkg::DIV_STEP_W-1:0]     step_q;
	logic [srde_pkg::VALUE_W-1:0]        quot_q;
	logic [srde_pkg::DIGIT_W-1:0]        rem_q;

	logic [srde_pkg::DIGIT_W-1:0]        rem_nxt;
	logic [srde_pkg::DIV_BITS-1:0]       qbits;
	logic                                step_last;

	// restoring division, DIV_BITS quotient bits per cycle; remainder stays below divisor
	always_comb begin
		logic [srde_pkg::RADIX_W-1:0] trial;
		logic [srde_pkg::DIGIT_W-1:0] r;
		r = rem_q;
		qbits = '0;
		for (int i = 0; i < srde_pkg::DIV_BITS; i++) begin
			trial = {r, quot_q[srde_pkg::VALUE_W-1-i]};
			if (trial >= ctl.divisor) begin
				trial = trial - ctl.divisor;
				qbits[srde_pkg::DIV_BITS-1-i] = 1'b1;
			end
			r = trial[srde_pkg::DIGIT_W-1:0];
		end
		rem_nxt = r;
	end

	assign step_last = (step_q == srde_pkg::DIV_STEP_W'(srde_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && step_last;
			if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_last)
					busy_q <= 1'b0;
			end else if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			quot_q <= {quot_q[srde_pkg::VALUE_W-srde_pkg::DIV_BITS-1:0], qbits};
			rem_q  <= rem_nxt;
		end else if (ctl.start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/signed_radix_digit_emitter.sv =====
// Integer to text converter.
// s_* channel: one signed 32-bit value per item. m_* channel: one character per
// item, '-' first for a negative value, then the digits most significant first;
// tlast marks the final character of a value's text.
// cfg_we/cfg_addr/cfg_wdata write radix (0), alphabet chars 0..7 (1) and chars 8..15
// (2), one register per cycle; the user must write them only while the block is idle,
// which the block itself does not enforce. An alphabet that is invalid (radix below 2,
// above MAX_RADIX or above 16, repeated chars, '+', '-', control, space, DEL or bytes
// from 128 up) makes an item produce nothing. Steps: accept, check the alphabet, then
// for each digit a pass of the shared divider (steps of 8 quotient bits each plus a
// hand-off), then one character per cycle while the receiver takes them. One item is
// in work at a time; s_tready is high only when idle. The last character may still
// sit in the output register when the next item is accepted. A stalled receiver holds
// the character and pauses emission.
// Reset clears the registers to zero (invalid alphabet) and drops any pending output.
module signed_radix_digit_emitter #(
	parameter int unsigned MAX_RADIX = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [srde_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [srde_pkg::ALPHA_W-1:0]        cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic signed [srde_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [srde_pkg::CHAR_W-1:0]         m_tdata,  // [7:0] out_char
	output logic                                m_tlast   // last_char
);

	logic [srde_pkg::RADIX_W-1:0]  radix_q;
	logic [srde_pkg::ALPHA_W-1:0]  alpha_lo_q;
	logic [srde_pkg::ALPHA_W-1:0]  alpha_hi_q;

	srde_pkg::state_t              state_q;
	logic                          neg_q;
	logic                          sign_pend_q;
	logic [srde_pkg::VALUE_W-1:0]  mag_q;
	logic [srde_pkg::COUNT_W-1:0]  cnt_q;
	logic [srde_pkg::DIGIT_W-1:0]  stack_q [srde_pkg::STACK_DEPTH];

	logic                          m_tvalid_q;
	logic [srde_pkg::CHAR_W-1:0]   m_tdata_q;
	logic                          m_tlast_q;

	logic [srde_pkg::CHAR_W-1:0]   chars [srde_pkg::NUM_CHARS];
	logic                          alpha_ok;
	logic                          in_acc;
	logic                          out_free;
	logic [$clog2(srde_pkg::STACK_DEPTH)-1:0] rd_idx;
	logic                          div_last;

	srde_pkg::div_ctl_t            div_ctl;
	srde_pkg::div_stat_t           div_st;
	logic [srde_pkg::VALUE_W-1:0]  div_a;
	logic [srde_pkg::VALUE_W-1:0]  div_q;
	logic [srde_pkg::DIGIT_W-1:0]  div_r;

	always_comb begin
		for (int i = 0; i < srde_pkg::NUM_CHARS / 2; i++) begin
			chars[i] = alpha_lo_q[srde_pkg::CHAR_W*i +: srde_pkg::CHAR_W];
			chars[i + srde_pkg::NUM_CHARS / 2] = alpha_hi_q[srde_pkg::CHAR_W*i +: srde_pkg::CHAR_W];
		end
	end

	// alphabet check over the characters in use
	always_comb begin
		logic used_i;
		logic used_j;
		alpha_ok = (radix_q >= srde_pkg::MIN_RADIX) &&
			({27'd0, radix_q} <= MAX_RADIX) &&
			(radix_q <= srde_pkg::RADIX_W'(srde_pkg::NUM_CHARS));
		for (int i = 0; i < srde_pkg::NUM_CHARS; i++) begin
			used_i = (srde_pkg::RADIX_W'(i) < radix_q);
			if (used_i && (chars[i] <= srde_pkg::CHAR_SPACE || chars[i] >= srde_pkg::CHAR_DEL ||
				chars[i] == srde_pkg::CHAR_PLUS || chars[i] == srde_pkg::CHAR_MINUS))
				alpha_ok = 1'b0;
			for (int j = i + 1; j < srde_pkg::NUM_CHARS; j++) begin
				used_j = (srde_pkg::RADIX_W'(j) < radix_q);
				if (used_j && chars[i] == chars[j])
					alpha_ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= '0;
			alpha_lo_q <= '0;
			alpha_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				srde_pkg::REG_RADIX:    radix_q <= cfg_wdata[srde_pkg::RADIX_W-1:0];
				srde_pkg::REG_ALPHA_LO: alpha_lo_q <= cfg_wdata;
				srde_pkg::REG_ALPHA_HI: alpha_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == srde_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_idx   = cnt_q[$clog2(srde_pkg::STACK_DEPTH)-1:0] - 1'b1;
	assign div_last = (div_q == '0) ||
		(cnt_q == srde_pkg::COUNT_W'(srde_pkg::STACK_DEPTH - 1));

	assign div_ctl.divisor = radix_q;
	assign div_ctl.start = ((state_q == srde_pkg::ST_CHECK) && alpha_ok) ||
		((state_q == srde_pkg::ST_DIV) && div_st.done && !div_last);
	assign div_a = (state_q == srde_pkg::ST_CHECK) ? mag_q : div_q;

	srde_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_a),
		.stat      (div_st),
		.quotient  (div_q),
		.remainder (div_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srde_pkg::ST_IDLE;
			neg_q       <= 1'b0;
			sign_pend_q <= 1'b0;
			cnt_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (state_q == srde_pkg::ST_EMIT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				srde_pkg::ST_IDLE: begin
					if (in_acc) begin
						neg_q   <= s_tdata[srde_pkg::VALUE_W-1];
						state_q <= srde_pkg::ST_CHECK;
					end
				end
				srde_pkg::ST_CHECK: begin
					cnt_q       <= '0;
					sign_pend_q <= neg_q;
					state_q     <= alpha_ok ? srde_pkg::ST_DIV : srde_pkg::ST_IDLE;
				end
				srde_pkg::ST_DIV: begin
					if (div_st.done) begin
						cnt_q <= cnt_q + 1'b1;
						if (div_last)
							state_q <= srde_pkg::ST_EMIT;
					end
				end
				srde_pkg::ST_EMIT: begin
					if (out_free) begin
						if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - 1'b1;
							if (cnt_q == srde_pkg::COUNT_W'(1))
								state_q <= srde_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= srde_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc)
			mag_q <= s_tdata[srde_pkg::VALUE_W-1] ? (srde_pkg::VALUE_W'(0) - s_tdata) : s_tdata;
		if (state_q == srde_pkg::ST_DIV && div_st.done)
			stack_q[cnt_q[$clog2(srde_pkg::STACK_DEPTH)-1:0]] <= div_r;
		if (state_q == srde_pkg::ST_EMIT && out_free) begin
			if (sign_pend_q) begin
				m_tdata_q <= srde_pkg::CHAR_MINUS;
				m_tlast_q <= 1'b0;
			end else begin
				m_tdata_q <= chars[stack_q[rd_idx]];
				m_tlast_q <= (cnt_q == srde_pkg::COUNT_W'(1));
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_acc_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == srde_pkg::ST_CHECK)
		else $error("accepted item did not move to alphabet check");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= srde_pkg::COUNT_W'(srde_pkg::STACK_DEPTH))
		else $error("digit count beyond stack depth");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == srde_pkg::ST_DIV)
		else $error("divider finished outside the divide phase");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == srde_pkg::ST_EMIT |-> cnt_q != '0)
		else $error("emitting with no digits held");

endmodule

// ===== verif/signed_radix_digit_emitter_test.sv =====
module signed_radix_digit_emitter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import srde_pkg::*;

	localparam int unsigned MAX_RADIX = 16;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 250;
	localparam logic [127:0] DIGITS_HEX = {"FEDCBA98", "76543210"};

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              is_last;
	} glyph_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_addr = '0;
	logic [ALPHA_W-1:0]        cfg_wdata = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic signed [VALUE_W-1:0] s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [CHAR_W-1:0]         m_tdata;
	logic                      m_tlast;

	// shadow of the block's registers
	logic [RADIX_W-1:0] cur_radix = '0;
	logic [127:0]       cur_alpha = '0;

	logic [VALUE_W-1:0] pending_values[$];
	glyph_t             text_due[$];
	glyph_t             due_glyph;
	int                 fail_count = 0;
	int                 chars_seen = 0;

	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	bit          long_hold_done = 1'b0;
	int unsigned rx_mode = 0;
	int unsigned mode_left = 0;

	signed_radix_digit_emitter #(.MAX_RADIX(MAX_RADIX)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [CHAR_W-1:0] glyph_at(input int unsigned idx);
		return cur_alpha[8*idx +: 8];
	endfunction

	function automatic bit alphabet_usable();
		int unsigned n;
		logic [CHAR_W-1:0] c;
		n = 32'(cur_radix);
		if (n < MIN_RADIX || n > MAX_RADIX)
			return 1'b0;
		for (int unsigned i = 0; i < n; i++) begin
			c = glyph_at(i);
			if (c <= CHAR_SPACE || c >= CHAR_DEL || c == CHAR_PLUS || c == CHAR_MINUS)
				return 1'b0;
			for (int unsigned j = i + 1; j < n; j++)
				if (glyph_at(j) == c)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// queue the characters one accepted value turns into
	function automatic void predict_text(input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] base;
		logic [DIGIT_W-1:0] digs[STACK_DEPTH];
		int n;
		if (!alphabet_usable())
			return;
		base = VALUE_W'(cur_radix);
		mag = v[VALUE_W-1] ? ~v + 1'b1 : v;
		n = 0;
		do begin
			digs[n] = DIGIT_W'(mag % base);
			n++;
			mag = mag / base;
		end while (mag != 0 && n < STACK_DEPTH);
		if (v[VALUE_W-1])
			text_due.push_back('{ch: CHAR_MINUS, is_last: 1'b0});
		for (int k = n - 1; k >= 0; k--)
			text_due.push_back('{ch: glyph_at(32'(digs[k])), is_last: (k == 0)});
	endfunction

	// sender: bursts of items with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_text(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_values.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_values.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 8);
						gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern changes at random intervals, plus one long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!long_hold_done && chars_seen >= 400 && pending_values.size() != 0) begin
			hold_left <= 600;
			long_hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 120);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 4) == 0);
				default: m_tready <= (mode_left[1:0] != 2'd0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			chars_seen <= chars_seen + 1;
			if (text_due.size() == 0) begin
				$error("out_char: expected nothing, got %h", m_tdata);
				fail_count++;
			end else begin
				due_glyph = text_due.pop_front();
				if (m_tdata !== due_glyph.ch) begin
					$error("out_char: expected %h, got %h", due_glyph.ch, m_tdata);
					fail_count++;
				end
				if (m_tlast !== due_glyph.is_last) begin
					$error("last_char: expected %b, got %b", due_glyph.is_last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_RADIX:    cur_radix = data[RADIX_W-1:0];
			REG_ALPHA_LO: cur_alpha[63:0] = data;
			REG_ALPHA_HI: cur_alpha[127:64] = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_alphabet(input logic [RADIX_W-1:0] r, input logic [127:0] a);
		logic [ALPHA_W-1:0] rword;
		rword = {$urandom(), $urandom()};
		rword[RADIX_W-1:0] = r;
		write_reg(REG_ALPHA_HI, a[127:64]);
		write_reg(REG_RADIX, rword);
		write_reg(REG_ALPHA_LO, a[63:0]);
	endtask

	// wait until the sender is quiet and every character is back, then let the block drain
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_values.size() != 0 || s_tvalid || text_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [127:0] make_alphabet(input int unsigned n);
		logic [127:0] a;
		bit used[256];
		logic [CHAR_W-1:0] c;
		a = {$urandom(), $urandom(), $urandom(), $urandom()};
		for (int unsigned i = 0; i < n; i++) begin
			do c = CHAR_W'($urandom_range(33, 126));
			while (used[c] || c == CHAR_PLUS || c == CHAR_MINUS);
			used[c] = 1'b1;
			a[8*i +: 8] = c;
		end
		return a;
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [63:0] p;
		logic [VALUE_W-1:0] v;
		int unsigned r;
		r = 32'(cur_radix);
		case ($urandom_range(0, 5))
			0: v = $urandom();
			1: v = $urandom_range(0, 300);
			2: case ($urandom_range(0, 4))
				0: v = 32'h0;
				1: v = 32'hFFFF_FFFF;
				2: v = 32'h7FFF_FFFF;
				3: v = 32'h8000_0000;
				default: v = 32'h1;
			endcase
			3: begin
				p = 64'd1;
				if (r >= 2)
					repeat ($urandom_range(0, 31))
						if (p * r <= 64'h1_0000_0000)
							p = p * r;
				v = p[31:0] + $urandom_range(0, 2) - 1;
			end
			4: v = $urandom() >> $urandom_range(0, 31);
			default: v = $urandom() | 32'h8000_0000;
		endcase
		if ($urandom_range(0, 3) == 0)
			v = ~v + 1'b1;
		return v;
	endfunction

	initial begin
		logic [127:0] alpha;
		logic [RADIX_W-1:0] r;
		int unsigned pos;
		int unsigned pos2;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// registers still at reset: alphabet unusable, items vanish
		pending_values.push_back(32'd0);
		pending_values.push_back(32'hFFFF_FFFF);
		wait_idle();

		apply_alphabet(5'd10, DIGITS_HEX);
		pending_values.push_back(32'd0);
		pending_values.push_back(32'd7);
		pending_values.push_back(-32'sd7);
		pending_values.push_back(32'd10);
		pending_values.push_back(32'h7FFF_FFFF);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h8000_0001);
		pending_values.push_back(32'd1_000_000_000);
		wait_idle();

		// unused register index must leave the setup alone
		write_reg(REG_NONE, {$urandom(), $urandom()});
		pending_values.push_back(32'd42);
		pending_values.push_back(-32'sd100);
		wait_idle();

		apply_alphabet(5'd16, DIGITS_HEX);
		pending_values.push_back(32'hFFFF_FFFF);
		pending_values.push_back(32'h7FFF_FFFF);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'hDEAD_BEEF);
		wait_idle();

		// binary: bytes past the radix are junk and must not matter
		alpha = {~64'h0, 48'h80FF_0000_2D2B, "10"};
		apply_alphabet(5'd2, alpha);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h7FFF_FFFF);
		pending_values.push_back(32'd1);
		pending_values.push_back(32'd0);
		wait_idle();

		// unusable alphabets, one per flaw
		for (int k = 0; k < 12; k++) begin
			alpha = DIGITS_HEX;
			r = 5'd16;
			case (k)
				0: r = 5'd0;
				1: r = 5'd1;
				2: r = 5'd17;
				3: r = 5'd31;
				4: alpha[8*9 +: 8] = alpha[7:0];
				5: alpha[8*3 +: 8] = CHAR_PLUS;
				6: alpha[8*12 +: 8] = CHAR_MINUS;
				7: alpha[8*5 +: 8] = CHAR_DEL;
				8: alpha[8*1 +: 8] = CHAR_SPACE;
				9: alpha[8*0 +: 8] = 8'h00;
				10: alpha[8*7 +: 8] = 8'h80;
				default: alpha[8*15 +: 8] = 8'hFF;
			endcase
			apply_alphabet(r, alpha);
			pending_values.push_back(32'd123);
			wait_idle();
		end

		for (int ph = 0; ph < 10; ph++) begin
			r = (ph == 0) ? 5'd2 : (ph == 1) ? 5'd16 : RADIX_W'($urandom_range(2, 16));
			alpha = make_alphabet(32'(r));
			if (ph > 1 && $urandom_range(0, 4) == 0) begin
				pos = $urandom_range(0, r - 1);
				case ($urandom_range(0, 6))
					0: r = RADIX_W'($urandom_range(0, 1));
					1: r = RADIX_W'($urandom_range(17, 31));
					2: begin
						pos2 = $urandom_range(0, r - 1);
						if (pos2 == pos)
							pos2 = (pos + 1) % r;
						alpha[8*pos2 +: 8] = alpha[8*pos +: 8];
					end
					3: alpha[8*pos +: 8] = CHAR_PLUS;
					4: alpha[8*pos +: 8] = CHAR_MINUS;
					5: alpha[8*pos +: 8] = $urandom_range(0, 1) ? CHAR_DEL :
						CHAR_W'($urandom_range(128, 255));
					default: alpha[8*pos +: 8] = CHAR_W'($urandom_range(0, 32));
				endcase
			end
			apply_alphabet(r, alpha);
			repeat (30)
				pending_values.push_back(pick_value());
			wait_idle();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
